@@ hw/rtl/totp_pkg.sv @@
// Shared types, codes and constants of the one-time password verifier.
// Used by every module of the block; depends on nothing else.
package totp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_DIGITS = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;
    localparam logic [2:0] REG_STEP   = 3'd5;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    // Message bit lengths of the inner and outer hash inputs.
    localparam logic [63:0] INNER_BITS = 64'd576;
    localparam logic [63:0] OUTER_BITS = 64'd672;

    typedef struct packed {
        logic [62:0] counter;
        logic [29:0] code;
        logic        len_ok;
    } job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sha_stat_t;

    function automatic logic [29:0] pow_ten(input logic [3:0] digits);
        logic [29:0] r;
        case (digits)
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20)      k = 32'h5A827999;
        else if (t < 7'd40) k = 32'h6ED9EBA1;
        else if (t < 7'd60) k = 32'h8F1BBCDC;
        else                k = 32'hCA62C1D6;
        return k;
    endfunction

endpackage

@@ hw/rtl/totp_fifo.sv @@
// Two-entry queue that carries jobs from the front end to the hash back end.
// Depends on totp_pkg for the job type and the depth.
module totp_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  totp_pkg::job_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output totp_pkg::job_t  pop_data
);
    localparam int PW = (totp_pkg::QUEUE_DEPTH > 1) ? $clog2(totp_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(totp_pkg::QUEUE_DEPTH + 1);

    totp_pkg::job_t   slot_reg [totp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(totp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !full && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (pop && !empty && !(push && !full))
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == PW'(totp_pkg::QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == PW'(totp_pkg::QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(totp_pkg::QUEUE_DEPTH)) else $error("queue count overflow");
    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push lost");
    a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop lost");
`endif
endmodule

@@ hw/rtl/totp_front.sv @@
// Front end: takes an input transaction, checks the code length and divides
// the time by the step length one quotient bit a cycle. Depends on totp_pkg.
module totp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [29:0]     code_value,
    input  logic [3:0]      code_length,
    input  logic [62:0]     unix_time,
    input  logic [3:0]      digits,
    input  logic [15:0]     step_seconds,
    output logic            push,
    output totp_pkg::job_t  push_data,
    input  logic            full
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [62:0] quot_reg;
    logic [15:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [29:0] code_reg;
    logic        len_ok_reg;
    logic [15:0] step;
    logic [16:0] trial;
    logic        fits;

    assign step     = (step_seconds == '0) ? 16'd1 : step_seconds;
    assign trial    = {rem_reg, quot_reg[62]};
    assign fits     = (trial >= {1'b0, step});
    assign in_stall = (state_reg != ST_IDLE);
    assign push     = (state_reg == ST_PUSH);
    assign push_data = '{counter: quot_reg, code: code_reg, len_ok: len_ok_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 6'd62) state_next = ST_PUSH;
            ST_PUSH: if (!full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                quot_reg   <= unix_time;
                rem_reg    <= '0;
                cnt_reg    <= '0;
                code_reg   <= code_value;
                len_ok_reg <= (code_length == digits);
            end
            ST_DIV:
            begin
                rem_reg  <= fits ? 16'(trial - {1'b0, step}) : trial[15:0];
                quot_reg <= {quot_reg[61:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < step)) else $error("remainder too large");
    a_push_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(push) |-> $past(state_reg == ST_DIV)) else $error("push without divide");
    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DIV)) else $error("take lost");
`endif
endmodule

@@ hw/rtl/totp_sha1.sv @@
// SHA-1 compression unit: one round a cycle, with the message schedule held in a
// 16-word shift register. Depends on totp_pkg.
module totp_sha1 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [159:0]        h_in,
    input  logic [511:0]        blk,
    output totp_pkg::sha_stat_t stat,
    output logic [159:0]        h_out
);
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  w_reg [16];
    logic [159:0] base_reg;
    logic [6:0]   t_reg;
    logic         busy_reg, done_reg;
    logic [31:0]  f, tmp, w_new, wx;

    always_comb
    begin
        if (t_reg < 7'd20)      f = (b_reg & c_reg) | (~b_reg & d_reg);
        else if (t_reg < 7'd40) f = b_reg ^ c_reg ^ d_reg;
        else if (t_reg < 7'd60) f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
        else                    f = b_reg ^ c_reg ^ d_reg;
        tmp   = {a_reg[26:0], a_reg[31:27]} + f + e_reg + totp_pkg::round_k(t_reg)
              + w_reg[0];
        wx    = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {wx[30:0], wx[31]};
    end

    assign stat  = '{busy: busy_reg, done: done_reg};
    assign h_out = {base_reg[159:128] + a_reg, base_reg[127:96] + b_reg,
                    base_reg[95:64] + c_reg, base_reg[63:32] + d_reg,
                    base_reg[31:0] + e_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (t_reg == 7'd79);
            if (start)
                busy_reg <= 1'b1;
            else if (t_reg == 7'd79)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg <= h_in;
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= h_in;
            t_reg <= '0;
            for (int j = 0; j < 16; j++)
                w_reg[j] <= blk[511 - 32*j -: 32];
        end
        else if (busy_reg)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            t_reg <= t_reg + 1'b1;
            for (int j = 0; j < 15; j++)
                w_reg[j] <= w_reg[j+1];
            w_reg[15] <= w_new;
        end
    end
endmodule

@@ hw/rtl/totp_back.sv @@
// Back end: walks the window, runs four compressions per candidate counter,
// truncates and reduces modulo ten to the digit count. Depends on totp_pkg
// and totp_sha1.
module totp_back #(
    parameter int MAX_WINDOW = 15,
    parameter int KEY_BYTES  = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  totp_pkg::job_t  pop_data,
    output logic            pop,
    input  logic [159:0]    key,
    input  logic [3:0]      digits,
    input  logic [3:0]      window_steps,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            accepted
);
    localparam int WIN_W = $clog2(MAX_WINDOW + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]       state_reg;
    logic [1:0]       phase_reg;
    logic [62:0]      ctr_reg;
    logic [29:0]      code_reg;
    logic [WIN_W-1:0] idx_reg, win;
    logic             minus_reg, ok_reg, res_valid_reg, res_reg;
    logic [159:0]     chain_reg, inner_reg;
    logic [30:0]      bin_reg, rem_reg;
    logic [4:0]       bit_cnt_reg;

    logic             sha_start;
    logic [159:0]     sha_h;
    logic [511:0]     sha_blk;
    totp_pkg::sha_stat_t sha_stat;
    logic [159:0]     sha_out;

    logic [159:0]     key_m;
    logic [511:0]     ipad_blk, opad_blk;
    logic [63:0]      cand;
    logic [29:0]      modulus;
    logic [31:0]      trunc;
    logic [30:0]      rem_try;
    logic             rem_fits;

    assign win = (window_steps > 4'(MAX_WINDOW > 15 ? 15 : MAX_WINDOW))
               ? WIN_W'(MAX_WINDOW) : WIN_W'(window_steps);
    assign modulus = totp_pkg::pow_ten(digits);

    always_comb
    begin
        for (int i = 0; i < 20; i++)
            key_m[159 - 8*i -: 8] = (i < KEY_BYTES) ? key[159 - 8*i -: 8] : 8'h00;
        ipad_blk = {key_m, 352'b0} ^ {64{totp_pkg::IPAD}};
        opad_blk = {key_m, 352'b0} ^ {64{totp_pkg::OPAD}};
    end

    assign cand = minus_reg ? ({1'b0, ctr_reg} - 64'(idx_reg))
                            : ({1'b0, ctr_reg} + 64'(idx_reg));

    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                sha_h   = totp_pkg::SHA1_IV;
                sha_blk = ipad_blk;
            end
            2'd1:
            begin
                sha_h   = chain_reg;
                sha_blk = {cand, 8'h80, 376'b0, totp_pkg::INNER_BITS};
            end
            2'd2:
            begin
                sha_h   = totp_pkg::SHA1_IV;
                sha_blk = opad_blk;
            end
            default:
            begin
                sha_h   = chain_reg;
                sha_blk = {inner_reg, 8'h80, 280'b0, totp_pkg::OUTER_BITS};
            end
        endcase
    end

    // Dynamic truncation: the low nibble of the last byte picks the word.
    assign trunc    = 32'((sha_out << {sha_out[3:0], 3'b000}) >> 128);
    assign rem_try  = {rem_reg[29:0], bin_reg[30]};
    assign rem_fits = (rem_try >= {1'b0, modulus});
    assign sha_start = (state_reg == ST_ISSUE);
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign out_valid = res_valid_reg;
    assign accepted  = res_reg;

    totp_sha1 u_sha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sha_start),
        .h_in  (sha_h),
        .blk   (sha_blk),
        .stat  (sha_stat),
        .h_out (sha_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !out_stall && state_reg != ST_RESULT)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (!empty)
                        state_reg <= pop_data.len_ok ? ST_ISSUE : ST_RESULT;
                ST_ISSUE:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                    if (sha_stat.done)
                        state_reg <= (phase_reg == 2'd3) ? ST_MOD : ST_ISSUE;
                ST_MOD:
                    if (bit_cnt_reg == 5'd30)
                        state_reg <= ST_CHECK;
                ST_CHECK:
                    if (rem_reg == {1'b0, code_reg} || (idx_reg == win && minus_reg)
                        || (idx_reg == win && idx_reg == '0))
                        state_reg <= ST_RESULT;
                    else
                        state_reg <= ST_ISSUE;
                ST_RESULT:
                    if (!res_valid_reg || !out_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ctr_reg   <= pop_data.counter;
                code_reg  <= pop_data.code;
                ok_reg    <= 1'b0;
                idx_reg   <= '0;
                minus_reg <= 1'b0;
                phase_reg <= 2'd0;
            end
            ST_WAIT:
                if (sha_stat.done)
                begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd1)
                        inner_reg <= sha_out;
                    else
                        chain_reg <= sha_out;
                    bin_reg     <= {1'b0, trunc[29:0]} | {trunc[30], 30'b0};
                    rem_reg     <= '0;
                    bit_cnt_reg <= '0;
                end
            ST_MOD:
            begin
                rem_reg     <= rem_fits ? rem_try - {1'b0, modulus} : rem_try;
                bin_reg     <= {bin_reg[29:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            ST_CHECK:
            begin
                ok_reg <= (rem_reg == {1'b0, code_reg});
                if (!minus_reg && idx_reg != '0)
                    minus_reg <= 1'b1;
                else
                begin
                    minus_reg <= 1'b0;
                    idx_reg   <= idx_reg + 1'b1;
                end
            end
            ST_RESULT:
                if (!res_valid_reg || !out_stall)
                    res_reg <= ok_reg;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        sha_start |-> !sha_stat.busy) else $error("hash unit restarted while busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (rem_reg < {1'b0, modulus})) else $error("bad remainder");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_ISSUE || state_reg == ST_RESULT))
        else $error("job lost");
    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && !(res_valid_reg && out_stall)) |=> res_valid_reg)
        else $error("result not posted");
`endif
endmodule

@@ hw/rtl/totp_window_verifier.sv @@
// Top level of the one-time password verifier: register port, front end,
// job queue and hash back end. Depends on totp_pkg, totp_front, totp_fifo, totp_back.
//
// Usage: write the key, digit count, window and step registers over the
// register port while the block is idle. Each input transaction carries a
// code, its length and the Unix time; every one yields exactly one output
// transaction whose accepted bit is set when the code matches a password in
// the window. The front end divides the time and queues the job. The back end
// runs four SHA-1 compressions per candidate (each an issue step, the rounds
// and a done step), then the remainder and a compare step; with a window of
// w steps it tries up to 2w+1 candidate counters. A failed length check
// skips the hashing. The hash unit sets the rate. Results wait in an output
// register while out_stall is high, and the front end keeps taking items
// until the two-entry queue fills. Reset clears control state and loads the
// register defaults; no clearing pass is needed.
module totp_window_verifier #(
    parameter int MAX_WINDOW = 15,
    parameter int KEY_BYTES  = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [29:0] code_value,
    input  logic [3:0]  code_length,
    input  logic [62:0] unix_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted
);
    logic [63:0] key0_reg, key1_reg;
    logic [31:0] key2_reg;
    logic [3:0]  digits_reg, window_reg, digits;
    logic [15:0] step_reg;
    logic        wr_en;

    logic           push, full, pop, empty;
    totp_pkg::job_t push_data, pop_data;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign digits = (digits_reg == 4'd0) ? 4'd1 : (digits_reg > 4'd9) ? 4'd9 : digits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            digits_reg <= 4'd6;
            window_reg <= 4'd1;
            step_reg   <= 16'd30;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                totp_pkg::REG_KEY0:   key0_reg   <= pwdata;
                totp_pkg::REG_KEY1:   key1_reg   <= pwdata;
                totp_pkg::REG_KEY2:   key2_reg   <= pwdata[31:0];
                totp_pkg::REG_DIGITS: digits_reg <= pwdata[3:0];
                totp_pkg::REG_WINDOW: window_reg <= pwdata[3:0];
                totp_pkg::REG_STEP:   step_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            totp_pkg::REG_KEY0:   prdata = key0_reg;
            totp_pkg::REG_KEY1:   prdata = key1_reg;
            totp_pkg::REG_KEY2:   prdata = {32'b0, key2_reg};
            totp_pkg::REG_DIGITS: prdata = {60'b0, digits_reg};
            totp_pkg::REG_WINDOW: prdata = {60'b0, window_reg};
            totp_pkg::REG_STEP:   prdata = {48'b0, step_reg};
            default:              prdata = '0;
        endcase
    end

    totp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_value   (code_value),
        .code_length  (code_length),
        .unix_time    (unix_time),
        .digits       (digits),
        .step_seconds (step_reg),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    totp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    totp_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .KEY_BYTES  (KEY_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .key          ({key0_reg, key1_reg, key2_reg}),
        .digits       (digits),
        .window_steps (window_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted)
    );
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the one-time password window verifier.
// Depends on totp_pkg and totp_window_verifier; it holds its own HMAC-SHA1 predictor.
module testbench;

    // Predicts the accepted bit of every code transaction and checks results in order.
    class otp_scoreboard;
        logic [63:0] key_hi, key_mid;
        logic [31:0] key_lo;
        logic [3:0]  digits, window;
        logic [15:0] step;
        bit          accept_q[$];
        int          failures;

        function new();
            key_hi = '0; key_mid = '0; key_lo = '0;
            digits = 4'd6; window = 4'd1; step = 16'd30;
            failures = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                totp_pkg::REG_KEY0:   key_hi  = val;
                totp_pkg::REG_KEY1:   key_mid = val;
                totp_pkg::REG_KEY2:   key_lo  = val[31:0];
                totp_pkg::REG_DIGITS: digits  = val[3:0];
                totp_pkg::REG_WINDOW: window  = val[3:0];
                totp_pkg::REG_STEP:   step    = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [159:0] compress(logic [159:0] h, logic [511:0] blk);
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
            for (int i = 16; i < 80; i++)
            begin
                t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {t[30:0], t[31]};
            end
            {a, b, c, d, e} = h;
            for (int i = 0; i < 80; i++)
            begin
                if (i < 20)      begin f = (b & c) | (~b & d);          k = 32'h5A827999; end
                else if (i < 40) begin f = b ^ c ^ d;                   k = 32'h6ED9EBA1; end
                else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
                else             begin f = b ^ c ^ d;                   k = 32'hCA62C1D6; end
                t = {a[26:0], a[31:27]} + f + e + k + w[i];
                e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
            end
            return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
        endfunction

        function logic [3:0] sat_digits();
            if (digits < 4'd1) return 4'd1;
            if (digits > 4'd9) return 4'd9;
            return digits;
        endfunction

        function logic [63:0] step_counter(logic [62:0] now);
            logic [63:0] s;
            s = (step == 16'd0) ? 64'd1 : {48'd0, step};
            return {1'b0, now} / s;
        endfunction

        // Password for one counter value at the current key and digit count.
        function logic [29:0] password(logic [63:0] ctr);
            logic [511:0] key_blk;
            logic [159:0] inner, dig;
            logic [31:0]  bin;
            logic [31:0]  modulus;
            int           off;
            key_blk = {key_hi, key_mid, key_lo, 352'd0};
            inner = compress(compress(totp_pkg::SHA1_IV, key_blk ^ {64{totp_pkg::IPAD}}),
                             {ctr, 8'h80, 376'd0, totp_pkg::INNER_BITS});
            dig = compress(compress(totp_pkg::SHA1_IV, key_blk ^ {64{totp_pkg::OPAD}}),
                           {inner, 8'h80, 280'd0, totp_pkg::OUTER_BITS});
            off = dig[3:0];
            bin = dig[159 - 8 * off -: 32] & 32'h7FFFFFFF;
            modulus = 1;
            for (int i = 0; i < sat_digits(); i++) modulus = modulus * 10;
            return 30'(bin % modulus);
        endfunction

        function void note_code(logic [29:0] code, logic [3:0] len, logic [62:0] now);
            logic [63:0] c;
            bit ok;
            ok = 0;
            c = step_counter(now);
            if (len == sat_digits())
                for (int i = 0; i <= window && !ok; i++)
                    if (password(c + i) == code || (i != 0 && password(c - i) == code))
                        ok = 1;
            accept_q.push_back(ok);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            failures++;
        endtask

        task check_result(logic acc);
            if (accept_q.size() == 0)
                report($sformatf("unexpected result accepted=%0b", acc));
            else if (accept_q[0] !== acc)
                report($sformatf("accepted=%0b, predicted %0b", acc, accept_q[0]));
            if (accept_q.size() != 0) void'(accept_q.pop_front());
        endtask
    endclass

    logic        clk = 0, rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0, prdata;
    logic        pready;
    logic        in_valid = 0, in_stall;
    logic [29:0] code_value = '0;
    logic [3:0]  code_length = '0;
    logic [62:0] unix_time = '0;
    logic        out_valid, accepted;
    logic        out_stall = 0;

    otp_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_go = 0;

    totp_window_verifier DUT (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall) sb.check_result(accepted);

    // Receiver: alternates stall patterns, with one long hold-off on request.
    initial
    begin
        int mode, span, hold;
        hold = 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 400);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_go && hold == 0) begin hold = 6000; hold_go = 0; end
                if (hold > 0)
                begin
                    out_stall = 1;
                    hold--;
                end
                else if (mode == 0) out_stall = 0;
                else if (mode == 1) out_stall = ($urandom_range(0, 3) == 0);
                else                out_stall = ($urandom_range(0, 1) == 0);
            end
        end
    end

    task reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        psel = 1; pwrite = 1; penable = 0; paddr = {idx, 3'b000}; pwdata = val;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task settle();
        while (sb.accept_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task send_code(logic [29:0] code, logic [3:0] len, logic [62:0] now);
        @(negedge clk);
        if ($urandom_range(0, 4) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
        in_valid = 1; code_value = code; code_length = len; unix_time = now;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_code(code, len, now);
    endtask

    function logic [62:0] rand_time();
        return 63'({$urandom, $urandom});
    endfunction

    // Mostly valid passwords at a random drift, the rest near misses and noise.
    task random_codes(int n);
        logic [62:0] now;
        logic [63:0] c;
        logic [29:0] code;
        int          drift, kind;
        for (int j = 0; j < n; j++)
        begin
            now = ($urandom_range(0, 1)) ? rand_time() : 63'($urandom);
            c = sb.step_counter(now);
            drift = $urandom_range(0, sb.window + 1);
            code = sb.password($urandom_range(0, 1) ? c + drift : c - drift);
            kind = $urandom_range(0, 9);
            if (kind < 6)
                send_code(code, sb.sat_digits(), now);
            else if (kind < 8)
                send_code(code, 4'($urandom_range(0, 10)), now);
            else
                send_code(30'($urandom_range(0, 999999999)), 4'($urandom_range(0, 10)), now);
        end
        @(negedge clk);
        in_valid = 0;
    endtask

    initial
    begin
        logic [63:0] c;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Reset defaults: zero key, six digits, window of one, 30 s steps.
        c = sb.step_counter(63'd0);
        send_code(sb.password(c), 4'd6, 63'd0);
        send_code(sb.password(c - 1), 4'd6, 63'd29);
        send_code(sb.password(c + 1), 4'd6, 63'd15);
        send_code(sb.password(c), 4'd0, 63'd0);
        send_code(30'd999999999, 4'd10, 63'h7FFFFFFFFFFFFFFF);
        c = sb.step_counter(63'h7FFFFFFFFFFFFFFF);
        send_code(sb.password(c - 1), 4'd6, 63'h7FFFFFFFFFFFFFFF);
        send_code(sb.password(c + 2), 4'd6, 63'h7FFFFFFFFFFFFFFF);
        send_code(30'h3FFFFFFF, 4'd9, 63'd1234567890);
        @(negedge clk);
        in_valid = 0;
        settle();

        reg_write(totp_pkg::REG_KEY0, 64'h3132333435363738);
        reg_write(totp_pkg::REG_KEY1, 64'h3930313233343536);
        reg_write(totp_pkg::REG_KEY2, 64'h37383930);
        reg_write(totp_pkg::REG_DIGITS, 64'd8);
        reg_write(totp_pkg::REG_WINDOW, 64'd0);
        reg_write(totp_pkg::REG_STEP, 64'd30);
        send_code(30'd94287082, 4'd8, 63'd59);
        send_code(30'd7081804, 4'd8, 63'd1111111109);
        send_code(30'd7081804, 4'd7, 63'd1111111109);
        @(negedge clk);
        in_valid = 0;
        settle();

        // Queue fill: the receiver holds off while short jobs keep arriving.
        hold_go = 1;
        random_codes(15);
        settle();

        reg_write(totp_pkg::REG_KEY0, 64'hFFFFFFFFFFFFFFFF);
        reg_write(totp_pkg::REG_KEY1, 64'hFFFFFFFFFFFFFFFF);
        reg_write(totp_pkg::REG_KEY2, 64'hFFFFFFFF);
        reg_write(totp_pkg::REG_DIGITS, 64'd1);
        reg_write(totp_pkg::REG_WINDOW, 64'd2);
        reg_write(totp_pkg::REG_STEP, 64'd1);
        random_codes(20);
        settle();

        reg_write(totp_pkg::REG_DIGITS, 64'd9);
        reg_write(totp_pkg::REG_STEP, 64'd65535);
        reg_write(totp_pkg::REG_KEY0, {$urandom, $urandom});
        reg_write(totp_pkg::REG_KEY1, {$urandom, $urandom});
        reg_write(totp_pkg::REG_KEY2, {32'd0, $urandom});
        reg_write(totp_pkg::REG_WINDOW, 64'd1);
        random_codes(25);
        settle();

        // Out-of-range digit counts saturate, a zero step counts as one second.
        reg_write(totp_pkg::REG_DIGITS, 64'd0);
        reg_write(totp_pkg::REG_STEP, 64'd0);
        random_codes(10);
        settle();
        reg_write(totp_pkg::REG_DIGITS, 64'd15);
        random_codes(10);
        settle();

        reg_write(totp_pkg::REG_DIGITS, 64'd6);
        reg_write(totp_pkg::REG_STEP, 64'd30);
        reg_write(totp_pkg::REG_WINDOW, 64'd15);
        random_codes(5);
        settle();
        reg_write(totp_pkg::REG_WINDOW, 64'd3);
        random_codes(15);
        settle();

        repeat (200) @(posedge clk);
        if (sb.failures == 0 && sb.accept_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/totp_pkg.sv
hw/rtl/totp_fifo.sv
hw/rtl/totp_front.sv
hw/rtl/totp_sha1.sv
hw/rtl/totp_back.sv
hw/rtl/totp_window_verifier.sv
sim/testbench.sv
